// ===== sv/ftp_pkg.sv =====
// Package for the fading trail point buffer: register map, reset values,
// configuration bundle and the command and status bundles of the core.
`timescale 1ns / 1ps
package ftp_pkg;
   localparam int MAX_POINTS_DEF = 64;
   localparam int PADDR_W = 6;
   localparam int PDATA_W = 64;
   localparam int POS_W = 24;
   localparam int AGE_W = 16;
   localparam int LIMIT_W = 7;

   localparam logic [2:0] REG_FADE_RATE = 3'd0;
   localparam logic [2:0] REG_MIN_SEG = 3'd1;
   localparam logic [2:0] REG_MAX_SEG = 3'd2;
   localparam logic [2:0] REG_LIMIT = 3'd3;
   localparam logic [2:0] REG_OPACITY = 3'd4;

   localparam logic [15:0] FADE_RESET = 16'd256;
   localparam logic [6:0] LIMIT_RESET = 7'd64;
   localparam logic [7:0] OPACITY_RESET = 8'd255;
   localparam logic [AGE_W-1:0] AGE_FULL = 16'hFFFF;

   typedef struct packed {
      logic [15:0] fade_rate;
      logic [51:0] min_seg_sq;
      logic [51:0] max_seg_sq;
      logic [6:0] point_limit;
      logic [7:0] opacity;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic delta;
      logic cmp_wr;
      logic set_count;
      logic dx_last;
      logic dx_prev;
      logic sq;
      logic sum_last;
      logic sum_prev;
      logic decide;
      logic idx_clr;
      logic mark;
      logic e_hold;
      logic e_out;
   } cmd_type;

   typedef struct packed {
      logic known;
      logic cnt_done;
      logic cnt_zero;
      logic cnt_gt1;
      logic cnt_lt2;
      logic app_ok;
      logic last_pair;
      logic out_free;
   } status_type;
endpackage

// ===== sv/fading_trail_point_buffer_unit.sv =====
// Top level of the fading trail point buffer: registers, sequencer and datapath.
// Depends on ftp_pkg, ftp_regs, ftp_ctrl and ftp_dp.
//
//   channel  direction  handshake             beat
//   req      in         req_valid/req_stall   one frame
//   rsp      out        rsp_valid/rsp_stall   one segment or one marker
//   csr      in/out     psel/penable/pready   one register access
//
// A frame is handled in order: fade and compaction of the stored points, then
// the append check, then the segments one at a time, paced by the single read
// port of the point memory.
// Reset is synchronous and empties the store; the point memory needs no clearing.
// A stalled rsp beat holds the sequencer while req stays stalled.
`timescale 1ns / 1ps
module fading_trail_point_buffer_unit
   import ftp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_clear_first,
   input  logic req_position_known,
   input  logic req_active,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [15:0] req_dt,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_segment_valid,
   output logic signed [POS_W-1:0] rsp_start_x,
   output logic signed [POS_W-1:0] rsp_start_y,
   output logic signed [POS_W-1:0] rsp_end_x,
   output logic signed [POS_W-1:0] rsp_end_y,
   output logic [7:0] rsp_alpha,
   output logic rsp_last_segment,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic pready
);
   cfg_type cfg;
   cmd_type cmd;
   status_type st;

   assign pready = 1'b1;

   ftp_regs u_regs (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
   );

   ftp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .st(st), .cmd(cmd)
   );

   ftp_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg), .cmd(cmd), .st(st),
      .req_clear_first(req_clear_first), .req_position_known(req_position_known),
      .req_active(req_active), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_dt(req_dt), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_segment_valid(rsp_segment_valid), .rsp_start_x(rsp_start_x),
      .rsp_start_y(rsp_start_y), .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y),
      .rsp_alpha(rsp_alpha), .rsp_last_segment(rsp_last_segment)
   );
endmodule

// ===== sv/ftp_regs.sv =====
// Configuration registers behind the APB-style port.
// Depends on ftp_pkg for the register map and reset values.
`timescale 1ns / 1ps
module ftp_regs
   import ftp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output cfg_type cfg
);
   cfg_type cfg_ff;
   logic wr_en;
   logic [2:0] reg_sel;

   assign reg_sel = paddr[5:3];
   assign wr_en = psel & penable & pwrite;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_rate <= FADE_RESET;
         cfg_ff.min_seg_sq <= '0;
         cfg_ff.max_seg_sq <= '0;
         cfg_ff.point_limit <= LIMIT_RESET;
         cfg_ff.opacity <= OPACITY_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_FADE_RATE: cfg_ff.fade_rate <= pwdata[15:0];
            REG_MIN_SEG: cfg_ff.min_seg_sq <= pwdata[51:0];
            REG_MAX_SEG: cfg_ff.max_seg_sq <= pwdata[51:0];
            REG_LIMIT: cfg_ff.point_limit <= pwdata[6:0];
            REG_OPACITY: cfg_ff.opacity <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FADE_RATE: prdata = {48'd0, cfg_ff.fade_rate};
         REG_MIN_SEG: prdata = {12'd0, cfg_ff.min_seg_sq};
         REG_MAX_SEG: prdata = {12'd0, cfg_ff.max_seg_sq};
         REG_LIMIT: prdata = {57'd0, cfg_ff.point_limit};
         REG_OPACITY: prdata = {56'd0, cfg_ff.opacity};
         default: prdata = '0;
      endcase
   end
endmodule

// ===== sv/ftp_ctrl.sv =====
// Sequencer of the trail buffer: fade and compaction, append check, segment output.
// Depends on ftp_pkg for the command and status bundles.
`timescale 1ns / 1ps
module ftp_ctrl
   import ftp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  status_type st,
   output cmd_type cmd
);
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DELTA = 5'd1;
   localparam logic [4:0] S_CRD = 5'd2;
   localparam logic [4:0] S_CWR = 5'd3;
   localparam logic [4:0] S_APP = 5'd4;
   localparam logic [4:0] S_LA = 5'd5;
   localparam logic [4:0] S_LB = 5'd6;
   localparam logic [4:0] S_LC = 5'd7;
   localparam logic [4:0] S_PA = 5'd8;
   localparam logic [4:0] S_PB = 5'd9;
   localparam logic [4:0] S_PC = 5'd10;
   localparam logic [4:0] S_DEC = 5'd11;
   localparam logic [4:0] S_FIN = 5'd12;
   localparam logic [4:0] S_MARK = 5'd13;
   localparam logic [4:0] S_E0 = 5'd14;
   localparam logic [4:0] S_E0W = 5'd15;
   localparam logic [4:0] S_ERD = 5'd16;
   localparam logic [4:0] S_EOUT = 5'd17;

   logic [4:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DELTA;
            end
         end
         S_DELTA: begin
            cmd.delta = 1'b1;
            state_in = st.known ? S_CRD : S_FIN;
         end
         S_CRD: begin
            if (st.cnt_done) begin
               cmd.set_count = 1'b1;
               state_in = S_APP;
            end else begin
               state_in = S_CWR;
            end
         end
         S_CWR: begin
            cmd.cmp_wr = 1'b1;
            state_in = S_CRD;
         end
         S_APP: begin
            if (!st.app_ok) begin
               state_in = S_FIN;
            end else if (st.cnt_zero) begin
               state_in = S_DEC;
            end else begin
               state_in = S_LA;
            end
         end
         S_LA: begin
            cmd.dx_last = 1'b1;
            state_in = S_LB;
         end
         S_LB: begin
            cmd.sq = 1'b1;
            state_in = S_LC;
         end
         S_LC: begin
            cmd.sum_last = 1'b1;
            state_in = st.cnt_gt1 ? S_PA : S_DEC;
         end
         S_PA: begin
            cmd.dx_prev = 1'b1;
            state_in = S_PB;
         end
         S_PB: begin
            cmd.sq = 1'b1;
            state_in = S_PC;
         end
         S_PC: begin
            cmd.sum_prev = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.idx_clr = 1'b1;
            state_in = st.cnt_lt2 ? S_MARK : S_E0;
         end
         S_MARK: begin
            if (st.out_free) begin
               cmd.mark = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_E0: begin
            state_in = S_E0W;
         end
         S_E0W: begin
            cmd.e_hold = 1'b1;
            state_in = S_ERD;
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (st.out_free) begin
               cmd.e_out = 1'b1;
               state_in = st.last_pair ? S_IDLE : S_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ===== sv/ftp_dp.sv =====
// Datapath of the trail buffer: point memory, fade and compaction, distance unit,
// append decision and the segment output register. Depends on ftp_pkg.
`timescale 1ns / 1ps
module ftp_dp
   import ftp_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output status_type st,
   input  logic req_clear_first,
   input  logic req_position_known,
   input  logic req_active,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [15:0] req_dt,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_segment_valid,
   output logic signed [POS_W-1:0] rsp_start_x,
   output logic signed [POS_W-1:0] rsp_start_y,
   output logic signed [POS_W-1:0] rsp_end_x,
   output logic signed [POS_W-1:0] rsp_end_y,
   output logic [7:0] rsp_alpha,
   output logic rsp_last_segment
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
   localparam int EW = 2 * POS_W + AGE_W;
   localparam int SQW = 2 * POS_W + 2;
   localparam logic [LW-1:0] MAX_L = LW'(MAX_POINTS);

   logic [EW-1:0] mem [MAX_POINTS];
   logic [EW-1:0] rdata_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;

   logic kn_ff, ac_ff;
   logic [POS_W-1:0] px_ff, py_ff;
   logic [15:0] dt_ff;
   logic [23:0] delta_ff;
   logic [CW-1:0] count_ff, idx_ff, keep_ff;
   logic [POS_W-1:0] lx_ff, ly_ff, qx_ff, qy_ff, hx_ff, hy_ff;
   logic [AGE_W-1:0] ha_ff;
   logic signed [POS_W:0] dx_ff, dy_ff;
   logic [2*POS_W+1:0] sqx_ff, sqy_ff;
   logic [2*POS_W+2:0] dl_ff, dp_ff;

   logic [POS_W-1:0] rx, ry;
   logic [AGE_W-1:0] ra;
   logic survive;
   logic [LW-1:0] limit, cnt_l;
   logic brk, skip;
   logic [CW-1:0] base;
   logic [POS_W-1:0] sx, sy;
   logic signed [SQW-1:0] prod_x, prod_y;
   logic [AGE_W:0] age_sum;
   logic [AGE_W+8:0] alpha_prod;

   logic rv_ff, sv_ff, last_ff;
   logic [POS_W-1:0] osx_ff, osy_ff, oex_ff, oey_ff;
   logic [7:0] oa_ff;

   assign rx = rdata_ff[EW-1 -: POS_W];
   assign ry = rdata_ff[AGE_W +: POS_W];
   assign ra = rdata_ff[AGE_W-1:0];
   assign survive = {8'd0, ra} > delta_ff;

   assign cnt_l = LW'(count_ff);
   assign limit = (LW'(cfg.point_limit) > MAX_L) ? MAX_L : LW'(cfg.point_limit);
   assign brk = (count_ff != '0) && (cfg.max_seg_sq != '0) && ({1'b0, dl_ff} > cfg.max_seg_sq);
   assign skip = (count_ff != '0) && !brk &&
                 (({1'b0, dl_ff} < cfg.min_seg_sq) ||
                  ((count_ff > CW'(1)) && ({1'b0, dp_ff} < {cfg.min_seg_sq, 1'b0})));
   assign base = brk ? '0 : count_ff;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = keep_ff[AW-1:0];
      wr_data = {rx, ry, AGE_W'({8'd0, ra} - delta_ff)};
      if (cmd.cmp_wr && survive) begin
         wr_en = 1'b1;
      end else if (cmd.decide && !skip) begin
         wr_en = 1'b1;
         wr_addr = base[AW-1:0];
         wr_data = {px_ff, py_ff, AGE_FULL};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   assign sx = cmd.dx_prev ? qx_ff : lx_ff;
   assign sy = cmd.dx_prev ? qy_ff : ly_ff;
   assign prod_x = SQW'(dx_ff) * SQW'(dx_ff);
   assign prod_y = SQW'(dy_ff) * SQW'(dy_ff);
   assign age_sum = {1'b0, ha_ff} + {1'b0, ra};
   assign alpha_prod = age_sum * cfg.opacity;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kn_ff <= req_position_known;
         ac_ff <= req_active;
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         dt_ff <= req_dt;
      end
      if (cmd.delta) begin
         delta_ff <= 24'((32'(dt_ff) * 32'(cfg.fade_rate)) >> 8);
      end
      if (cmd.cmp_wr && survive) begin
         lx_ff <= rx;
         ly_ff <= ry;
         qx_ff <= lx_ff;
         qy_ff <= ly_ff;
      end
      if (cmd.dx_last || cmd.dx_prev) begin
         dx_ff <= $signed({px_ff[POS_W-1], px_ff}) - $signed({sx[POS_W-1], sx});
         dy_ff <= $signed({py_ff[POS_W-1], py_ff}) - $signed({sy[POS_W-1], sy});
      end
      if (cmd.sq) begin
         sqx_ff <= $unsigned(prod_x);
         sqy_ff <= $unsigned(prod_y);
      end
      if (cmd.sum_last) begin
         dl_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
      if (cmd.sum_prev) begin
         dp_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
      if (cmd.e_hold || cmd.e_out) begin
         hx_ff <= rx;
         hy_ff <= ry;
         ha_ff <= ra;
      end
      if (cmd.e_out) begin
         sv_ff <= 1'b1;
         osx_ff <= hx_ff;
         osy_ff <= hy_ff;
         oex_ff <= rx;
         oey_ff <= ry;
         oa_ff <= alpha_prod[AGE_W+8:AGE_W+1];
         last_ff <= st.last_pair;
      end else if (cmd.mark) begin
         sv_ff <= 1'b0;
         osx_ff <= '0;
         osy_ff <= '0;
         oex_ff <= '0;
         oey_ff <= '0;
         oa_ff <= '0;
         last_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff <= '0;
         keep_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            keep_ff <= '0;
            if (req_clear_first || !req_position_known) begin
               count_ff <= '0;
            end
         end
         if (cmd.cmp_wr) begin
            idx_ff <= idx_ff + 1'b1;
            if (survive) begin
               keep_ff <= keep_ff + 1'b1;
            end
         end
         if (cmd.set_count) begin
            count_ff <= keep_ff;
         end
         if (cmd.decide) begin
            count_ff <= skip ? count_ff : base + 1'b1;
         end
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end
         if (cmd.e_hold || cmd.e_out) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.e_out || cmd.mark) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign st.known = kn_ff;
   assign st.cnt_done = (idx_ff == count_ff);
   assign st.cnt_zero = (count_ff == '0);
   assign st.cnt_gt1 = (count_ff > CW'(1));
   assign st.cnt_lt2 = (count_ff < CW'(2));
   assign st.app_ok = ac_ff && (cnt_l < limit);
   assign st.last_pair = ((idx_ff + 1'b1) == count_ff);
   assign st.out_free = !rv_ff || !rsp_stall;

   assign rsp_valid = rv_ff;
   assign rsp_segment_valid = sv_ff;
   assign rsp_start_x = osx_ff;
   assign rsp_start_y = osy_ff;
   assign rsp_end_x = oex_ff;
   assign rsp_end_y = oey_ff;
   assign rsp_alpha = oa_ff;
   assign rsp_last_segment = last_ff;
endmodule

// ===== bench/tb_fading_trail_point_buffer_unit.sv =====
// Self-checking testbench for the fading trail point buffer unit.
// Drives frames and register writes, predicts every segment with an internal trail model
// and compares each result beat field by field. Depends on ftp_pkg and the unit's RTL.
`timescale 1ns / 1ps
module tb_fading_trail_point_buffer_unit
   import ftp_pkg::*;
();

   localparam int NPTS = 64;
   localparam int RUN_LIMIT = 2000000;

   typedef struct {
      logic       seg_ok;
      logic [23:0] sx;
      logic [23:0] sy;
      logic [23:0] ex;
      logic [23:0] ey;
      logic [7:0] alpha;
      logic       last;
   } segment_type;

   typedef struct {
      logic       clr;
      logic       known;
      logic       act;
      logic [23:0] x;
      logic [23:0] y;
      logic [15:0] dt;
      logic       fixed;
      logic       f_seg_ok;
      logic [7:0] f_alpha;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_clear_first = 1'b0;
   logic req_position_known = 1'b0;
   logic req_active = 1'b0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic [15:0] req_dt = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic rsp_segment_valid;
   logic signed [23:0] rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y;
   logic [7:0] rsp_alpha;
   logic rsp_last_segment;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [PDATA_W-1:0] pwdata = '0;
   logic [PDATA_W-1:0] prdata;
   logic pready;

   fading_trail_point_buffer_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Trail model state and settings.
   logic [15:0] m_fade;
   logic [51:0] m_min_sq;
   logic [51:0] m_max_sq;
   logic [6:0] m_limit;
   logic [7:0] m_opacity;
   logic [23:0] trail_x [NPTS];
   logic [23:0] trail_y [NPTS];
   logic [15:0] trail_age [NPTS];
   int trail_len;

   segment_type expected_segments[$];
   int errors = 0;
   int cycles = 0;
   bit rsp_idle_on = 1'b1;
   bit quiet_end = 1'b0;

   function automatic logic [63:0] span_sq(logic [23:0] ax, logic [23:0] ay,
                                           logic [23:0] bx, logic [23:0] by);
      longint dx, dy;
      dx = longint'($signed(ax)) - longint'($signed(bx));
      dy = longint'($signed(ay)) - longint'($signed(by));
      return 64'(dx * dx) + 64'(dy * dy);
   endfunction

   task automatic trail_advance(input frame_row_type f);
      int keep, lim, n;
      logic [31:0] delta;
      logic [63:0] d, d2;
      bit add;
      segment_type s;
      logic [31:0] sum;
      if (f.clr) trail_len = 0;
      if (!f.known) begin
         trail_len = 0;
      end else begin
         delta = (32'(f.dt) * 32'(m_fade)) >> 8;
         keep = 0;
         for (int i = 0; i < trail_len; i++) begin
            if (32'(trail_age[i]) > delta) begin
               trail_x[keep] = trail_x[i];
               trail_y[keep] = trail_y[i];
               trail_age[keep] = 16'(32'(trail_age[i]) - delta);
               keep++;
            end
         end
         trail_len = keep;
         lim = (m_limit > NPTS) ? NPTS : int'(m_limit);
         if (f.act && trail_len < lim) begin
            add = 1'b1;
            n = trail_len;
            if (n > 0) begin
               d = span_sq(f.x, f.y, trail_x[n-1], trail_y[n-1]);
               if (m_max_sq != 0 && d > 64'(m_max_sq)) trail_len = 0;
               else if (d < 64'(m_min_sq)) add = 1'b0;
               else if (n > 1) begin
                  d2 = span_sq(f.x, f.y, trail_x[n-2], trail_y[n-2]);
                  if (d2 < 64'(m_min_sq) * 2) add = 1'b0;
               end
            end
            if (add && trail_len < NPTS) begin
               trail_x[trail_len] = f.x;
               trail_y[trail_len] = f.y;
               trail_age[trail_len] = AGE_FULL;
               trail_len++;
            end
         end
      end
      if (trail_len < 2) begin
         s = '{1'b0, '0, '0, '0, '0, '0, 1'b1};
         expected_segments.insert(expected_segments.size(), s);
      end else begin
         for (int i = 0; i + 1 < trail_len; i++) begin
            sum = 32'(trail_age[i]) + 32'(trail_age[i+1]);
            s.seg_ok = 1'b1;
            s.sx = trail_x[i];
            s.sy = trail_y[i];
            s.ex = trail_x[i+1];
            s.ey = trail_y[i+1];
            s.alpha = 8'((sum * 32'(m_opacity)) >> 17);
            s.last = (i + 2 == trail_len);
            expected_segments.insert(expected_segments.size(), s);
         end
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(idx) << 3;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_FADE_RATE: m_fade = val[15:0];
         REG_MIN_SEG: m_min_sq = val[51:0];
         REG_MAX_SEG: m_max_sq = val[51:0];
         REG_LIMIT: m_limit = val[6:0];
         REG_OPACITY: m_opacity = val[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic settle;
      while (expected_segments.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_frame(input frame_row_type f, input bit gaps);
      if (gaps && !quiet_end && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 10)) @(posedge clock);
      req_valid <= 1'b1;
      req_clear_first <= f.clr;
      req_position_known <= f.known;
      req_active <= f.act;
      req_pos_x <= f.x;
      req_pos_y <= f.y;
      req_dt <= f.dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trail_advance(f);
      if (f.fixed) begin
         if (expected_segments[$].seg_ok !== f.f_seg_ok ||
             expected_segments[$].alpha !== f.f_alpha) begin
            $error("table row disagrees: seg_ok %0b alpha %0d", f.f_seg_ok, f.f_alpha);
            errors++;
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic frame_row_type rand_frame(input int spread, input int cx, input int cy);
      frame_row_type f;
      f.clr = ($urandom_range(0, 40) == 0);
      f.known = ($urandom_range(0, 30) != 0);
      f.act = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 15) == 0) begin
         f.x = 24'($urandom);
         f.y = 24'($urandom);
      end else begin
         f.x = 24'(cx + $urandom_range(0, 2 * spread) - spread);
         f.y = 24'(cy + $urandom_range(0, 2 * spread) - spread);
      end
      case ($urandom_range(0, 5))
         0: f.dt = 16'($urandom);
         1: f.dt = '0;
         default: f.dt = 16'($urandom_range(0, 3000));
      endcase
      f.fixed = 1'b0;
      f.f_seg_ok = 1'b0;
      f.f_alpha = '0;
      return f;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      segment_type s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_segments.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            s = expected_segments.pop_front();
            if (rsp_segment_valid !== s.seg_ok) begin
               $error("segment_valid exp %0b got %0b", s.seg_ok, rsp_segment_valid);
               errors++;
            end
            if (rsp_start_x !== s.sx) begin
               $error("start_x exp %0h got %0h", s.sx, rsp_start_x);
               errors++;
            end
            if (rsp_start_y !== s.sy) begin
               $error("start_y exp %0h got %0h", s.sy, rsp_start_y);
               errors++;
            end
            if (rsp_end_x !== s.ex) begin
               $error("end_x exp %0h got %0h", s.ex, rsp_end_x);
               errors++;
            end
            if (rsp_end_y !== s.ey) begin
               $error("end_y exp %0h got %0h", s.ey, rsp_end_y);
               errors++;
            end
            if (rsp_alpha !== s.alpha) begin
               $error("alpha exp %0d got %0d", s.alpha, rsp_alpha);
               errors++;
            end
            if (rsp_last_segment !== s.last) begin
               $error("last_segment exp %0b got %0b", s.last, rsp_last_segment);
               errors++;
            end
         end
      end
   end

   // Result-side stall bursts.
   initial begin
      @(negedge reset);
      forever begin
         if (rsp_idle_on && !quiet_end && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      frame_row_type rows[$];
      frame_row_type f;
      int cx, cy, spread;
      m_fade = FADE_RESET;
      m_min_sq = '0;
      m_max_sq = '0;
      m_limit = LIMIT_RESET;
      m_opacity = OPACITY_RESET;
      trail_len = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: clr, known, act, x, y, dt, fixed, seg_ok, alpha.
      rows.insert(rows.size(), '{0, 1, 1, 24'h000000, 24'h000000, 16'd0, 1, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h7FFFFF, 24'h7FFFFF, 16'd0, 1, 1, 8'd254});
      rows.insert(rows.size(), '{0, 1, 1, 24'h800000, 24'h800000, 16'd0, 1, 1, 8'd254});
      rows.insert(rows.size(), '{0, 1, 1, 24'h7FFFFF, 24'h800000, 16'd100, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 0, 24'h000100, 24'h000100, 16'hFFFF, 1, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h000100, 24'h000100, 16'd50, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h000200, 24'h000300, 16'd50, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h000200, 24'h000300, 16'd50, 0, 0, 8'd0});
      rows.insert(rows.size(), '{1, 1, 1, 24'h001000, 24'h002000, 16'd0, 1, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h001100, 24'h002000, 16'd0, 1, 1, 8'd254});
      rows.insert(rows.size(), '{0, 0, 1, 24'h001200, 24'h002000, 16'd0, 1, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h001200, 24'h002000, 16'd0, 0, 0, 8'd0});
      foreach (rows[i]) send_frame(rows[i], 1'b0);
      settle();

      // Minimum and maximum segment rules, maximum fade rate, point limit one, zero opacity.
      csr_write(REG_MIN_SEG, 64'd65536);
      csr_write(REG_MAX_SEG, 64'd1000000);
      csr_write(REG_OPACITY, 64'd0);
      csr_write(REG_FADE_RATE, 64'hFFFF);
      rows.delete();
      rows.insert(rows.size(), '{1, 1, 1, 24'h000000, 24'h000000, 16'd0, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h000080, 24'h000000, 16'd0, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h000100, 24'h000000, 16'd0, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h000080, 24'h000100, 16'd0, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h010000, 24'h000000, 16'd0, 0, 0, 8'd0});
      rows.insert(rows.size(), '{0, 1, 1, 24'h010000, 24'h000400, 16'd1, 0, 0, 8'd0});
      foreach (rows[i]) send_frame(rows[i], 1'b0);
      settle();
      csr_write(REG_LIMIT, 64'd1);
      csr_write(REG_MAX_SEG, 64'd0);
      csr_write(REG_MIN_SEG, 64'd0);
      f = '{1, 1, 1, 24'h000300, 24'h000300, 16'd0, 1, 0, 8'd0};
      send_frame(f, 1'b0);
      f.clr = 1'b0;
      send_frame(f, 1'b0);
      settle();

      // Random phases through several settings.
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_FADE_RATE, ph == 0 ? 64'd0 : 64'($urandom_range(0, 2000)));
         csr_write(REG_MIN_SEG, ph % 3 == 0 ? 64'd0 : 64'($urandom_range(0, 40000)));
         csr_write(REG_MAX_SEG, ph % 2 == 0 ? 64'd0 :
                   (ph == 7 ? 64'hF_FFFF_FFFF_FFFF : 64'($urandom_range(100000, 5000000))));
         csr_write(REG_LIMIT, ph == 3 ? 64'd0 : (ph == 5 ? 64'd127 :
                   64'($urandom_range(1, 64))));
         csr_write(REG_OPACITY, ph == 6 ? 64'd255 : 64'($urandom_range(0, 255)));
         quiet_end = (ph == 7);
         cx = 0;
         cy = 0;
         for (int k = 0; k < 58; k++) begin
            spread = ($urandom_range(0, 3) == 0) ? 4000 : 600;
            f = rand_frame(spread, cx, cy);
            cx = $signed(f.x);
            cy = $signed(f.y);
            send_frame(f, 1'b1);
         end
         settle();
      end

      if (errors == 0 && expected_segments.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== files.f =====
sv/ftp_pkg.sv
sv/ftp_regs.sv
sv/ftp_ctrl.sv
sv/ftp_dp.sv
sv/fading_trail_point_buffer_unit.sv
bench/tb_fading_trail_point_buffer_unit.sv
